### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the Modbus RTU receive deframer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted
`define MRX_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Clocked assertion that is also checked during reset
`define MRX_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

### src/mrx_pkg.sv
// ----------------------------------------------------------------------------
// mrx_pkg
// Types, constants and the CRC-16 byte update for the RTU receive deframer.
// ----------------------------------------------------------------------------
package mrx_pkg;

  // Frame and register defaults
  localparam int unsigned MaxFrameDef  = 256;
  localparam int unsigned RuntLimit    = 4;
  localparam logic [15:0] SilenceReset = 16'd4;

  // Modbus CRC-16, reflected
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // Field widths of a result item
  localparam int unsigned ByteW = 8;
  localparam int unsigned PosW  = 8;
  localparam int unsigned LenW  = 9;
  localparam int unsigned KindW = 3;
  localparam int unsigned TdataOutW = 32;

  // Result kinds
  typedef enum logic [KindW-1:0] {
    KindData     = 3'd0,
    KindGood     = 3'd1,
    KindCrcErr   = 3'd2,
    KindRunt     = 3'd3,
    KindOverflow = 3'd4
  } kind_e;

  // One result item
  typedef struct packed {
    kind_e             kind;
    logic [ByteW-1:0]  data_byte;
    logic [PosW-1:0]   position;
    logic [LenW-1:0]   frame_length;
  } res_t;

  // One byte through the CRC, LSB first
  function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### src/mrx_frame_ctrl.sv
// ----------------------------------------------------------------------------
// mrx_frame_ctrl
// Frame state, running CRC, byte and silence counters, result decision.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mrx_frame_ctrl #(
  parameter int unsigned MaxFrame = mrx_pkg::MaxFrameDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [15:0]                  cfg_data_i,
  input  logic                         fire_i,
  input  logic                         cmd_i,
  input  logic [mrx_pkg::ByteW-1:0]    byte_i,
  output logic                         res_valid_o,
  output mrx_pkg::res_t                res_o
);

  localparam int unsigned CntW = $clog2(MaxFrame + 1);

  logic [15:0]     ticks_q;
  logic            recv_q, recv_d;
  logic [15:0]     sil_q, sil_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [15:0]     crc_q, crc_d;
  logic            ovf_q, ovf_d;

  logic [CntW-1:0] cnt_base;
  logic [15:0]     crc_base;
  logic            ovf_base;
  logic [15:0]     sil_inc;

  // A byte while idle starts from a fresh frame
  assign cnt_base = recv_q ? cnt_q : '0;
  assign crc_base = recv_q ? crc_q : mrx_pkg::CrcInit;
  assign ovf_base = recv_q ? ovf_q : 1'b0;
  // Silence counter saturates
  assign sil_inc  = (sil_q == 16'hFFFF) ? sil_q : sil_q + 16'd1;

  // Next state and result
  always_comb begin
    recv_d      = recv_q;
    sil_d       = sil_q;
    cnt_d       = cnt_q;
    crc_d       = crc_q;
    ovf_d       = ovf_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.kind  = mrx_pkg::KindData;
    if (fire_i) begin
      if (cmd_i) begin
        recv_d = 1'b1;
        sil_d  = '0;
        cnt_d  = cnt_base;
        crc_d  = crc_base;
        ovf_d  = ovf_base;
        if (cnt_base >= CntW'(MaxFrame)) begin
          // frame full: drop the byte, remember the overflow
          ovf_d = 1'b1;
        end else begin
          crc_d             = mrx_pkg::crc_update(crc_base, byte_i);
          cnt_d             = CntW'(cnt_base + 1'b1);
          res_valid_o       = 1'b1;
          res_o.data_byte   = byte_i;
          res_o.position    = mrx_pkg::PosW'(cnt_base);
        end
      end else if (recv_q) begin
        if (sil_inc >= ticks_q) begin
          // end of frame: emit status and return to idle
          res_valid_o        = 1'b1;
          res_o.frame_length = mrx_pkg::LenW'(cnt_q);
          if (ovf_q) begin
            res_o.kind = mrx_pkg::KindOverflow;
          end else if (cnt_q < CntW'(mrx_pkg::RuntLimit)) begin
            res_o.kind = mrx_pkg::KindRunt;
          end else if (crc_q == 16'h0000) begin
            res_o.kind = mrx_pkg::KindGood;
          end else begin
            res_o.kind = mrx_pkg::KindCrcErr;
          end
          recv_d = 1'b0;
          sil_d  = '0;
          cnt_d  = '0;
          crc_d  = mrx_pkg::CrcInit;
          ovf_d  = 1'b0;
        end else begin
          sil_d = sil_inc;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= mrx_pkg::SilenceReset;
      recv_q  <= 1'b0;
      sil_q   <= '0;
      cnt_q   <= '0;
      crc_q   <= mrx_pkg::CrcInit;
      ovf_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ticks_q <= cfg_data_i;
      end
      recv_q <= recv_d;
      sil_q  <= sil_d;
      cnt_q  <= cnt_d;
      crc_q  <= crc_d;
      ovf_q  <= ovf_d;
    end
  end

  // Checks
  `MRX_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntW'(MaxFrame))
  `MRX_ASSERT(a_idle_clean, clk_i, rst_ni,
              !recv_q |-> (cnt_q == '0 && crc_q == mrx_pkg::CrcInit && !ovf_q && sil_q == '0))
  `MRX_ASSERT(a_status_ends, clk_i, rst_ni,
              (fire_i && res_valid_o && res_o.kind != mrx_pkg::KindData) |=> !recv_q)
  `MRX_ASSERT(a_data_counts, clk_i, rst_ni,
              (fire_i && res_valid_o && res_o.kind == mrx_pkg::KindData)
              |=> (recv_q && cnt_q == CntW'($past(cnt_base) + 1'b1)))

endmodule

### src/mrx_out_reg.sv
// ----------------------------------------------------------------------------
// mrx_out_reg
// Result register holding one item until the downstream side takes it.
// ----------------------------------------------------------------------------
module mrx_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  logic          res_valid_i,
  input  mrx_pkg::res_t res_i,
  output logic          space_o,
  output logic          valid_o,
  input  logic          ready_i,
  output mrx_pkg::res_t res_o
);

  logic          valid_q;
  mrx_pkg::res_t res_q;

  // Room for a new result when empty or when the held one leaves now
  assign space_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= res_valid_i;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

### src/modbus_rtu_rx_deframer.sv
// ----------------------------------------------------------------------------
// modbus_rtu_rx_deframer
// Modbus RTU receive deframer with running CRC-16 and silence timeout.
// ----------------------------------------------------------------------------
// Takes one item per clock while the result stream does not stall: a line byte
// (tuser = 1) or a time tick (tuser = 0). Each byte is forwarded with its frame position; when silence_ticks ticks of
// silence follow a frame, one status item (good, CRC error, runt, overflow)
// carries the frame length. Sustained rate is one item per cycle while
// m_axis_tready stays high. There is one input register, then the
// byte-wide CRC update and status decision feed the result
// register. Ticks while idle and bytes past MaxFrame give no result.
// silence_ticks may be written whenever the block is idle.
module modbus_rtu_rx_deframer #(
  parameter int unsigned MaxFrame = mrx_pkg::MaxFrameDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [15:0]                     cfg_data_i,    // silence_ticks
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [7:0] rx_byte
  input  logic                            s_axis_tuser,  // [0] cmd
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [7:0] data_byte, [15:8] position, [24:16] frame_length, [31:25] zero
  output logic [mrx_pkg::TdataOutW-1:0]   m_axis_tdata,
  output logic [mrx_pkg::KindW-1:0]       m_axis_tuser   // [2:0] kind
);

  logic          in_valid_q;
  logic          in_cmd_q;
  logic [7:0]    in_byte_q;
  logic          out_space;
  logic          adv;
  logic          res_valid;
  mrx_pkg::res_t res;
  mrx_pkg::res_t out_res;

  assign cfg_ready_o   = 1'b1;
  assign adv           = in_valid_q && out_space;
  assign s_axis_tready = !in_valid_q || out_space;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd_q  <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
  end

  // Frame state and decision
  mrx_frame_ctrl #(
    .MaxFrame (MaxFrame)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .fire_i      (adv),
    .cmd_i       (in_cmd_q),
    .byte_i      (in_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register
  mrx_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (adv),
    .res_valid_i (res_valid),
    .res_i       (res),
    .space_o     (out_space),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .res_o       (out_res)
  );

  assign m_axis_tuser = out_res.kind;
  assign m_axis_tdata = {7'b0, out_res.frame_length, out_res.position, out_res.data_byte};

endmodule
